// ===== rtl/core/jhd_pkg.sv =====
// shared types and constants of the jpeg huffman table decoder
// used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package jhd_pkg;

    localparam int MAX_SYMBOLS     = 256;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int NUM_LENGTHS     = 16;
    localparam int SYM_AW          = $clog2(MAX_SYMBOLS);
    // position just past the last symbol slot of a table
    localparam int POS_END         = NUM_LENGTHS + MAX_SYMBOLS;

    localparam logic MODE_TABLE  = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_SYMBOL    = 3'd0,
        ST_TABLE_OK  = 3'd1,
        ST_TABLE_BAD = 3'd2,
        ST_NO_DATA   = 3'd3,
        ST_BAD_CODE  = 3'd4
    } t_status;

    typedef struct packed {
        logic                               ready;
        logic [NUM_LENGTHS-1:0]             has_code;
        logic [NUM_LENGTHS-1:0][15:0]       first_code;
        logic [NUM_LENGTHS-1:0][15:0]       last_code;
        logic [NUM_LENGTHS-1:0][8:0]        first_index;
    } t_table;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_load_res;

    typedef struct packed {
        logic              en;
        logic [SYM_AW-1:0] addr;
        logic [7:0]        data;
    } t_sym_wr;

    typedef struct packed {
        t_status           status;
        logic [4:0]        len;
        logic [SYM_AW-1:0] addr;
    } t_match;

endpackage

`default_nettype wire

// ===== rtl/core/jhd_symbol_store.sv =====
// symbol value memory: one write port, one read port with registered data
// depends on jhd_pkg
`timescale 1ns / 1ps
`default_nettype none

module jhd_symbol_store (
    input  wire logic                      i_clk,
    input  wire jhd_pkg::t_sym_wr          i_wr,
    input  wire logic                      i_rd_en,
    input  wire logic [jhd_pkg::SYM_AW-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [jhd_pkg::MAX_SYMBOLS];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/jhd_table_builder.sv =====
// builds the canonical code table from dht bytes and checks the load
// depends on jhd_pkg; drives the symbol store write port
`timescale 1ns / 1ps
`default_nettype none

module jhd_table_builder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output jhd_pkg::t_table         o_tbl,
    output jhd_pkg::t_load_res      o_res,
    output jhd_pkg::t_sym_wr        o_wr
);

    logic [15:0] r_first_code  [jhd_pkg::NUM_LENGTHS];
    logic [15:0] r_last_code   [jhd_pkg::NUM_LENGTHS];
    logic [8:0]  r_first_index [jhd_pkg::NUM_LENGTHS];
    logic [jhd_pkg::NUM_LENGTHS-1:0] r_has_code;
    logic [8:0]  r_pos;
    logic [17:0] r_code;
    logic [9:0]  r_total;
    logic        r_failed;
    logic        r_ready;

    logic        w_first;
    logic [17:0] w_code;
    logic [9:0]  w_total;
    logic        w_failed;
    logic        w_count_phase;
    logic        w_value_ok;
    logic [3:0]  w_li;
    logic [18:0] w_sum;
    logic [18:0] w_lastc;
    logic [19:0] w_shift;
    logic [10:0] w_tsum;
    logic        w_ok;

    logic [8:0]  n_pos;
    logic [17:0] n_code;
    logic [9:0]  n_total;
    logic        n_failed;

    always_comb begin
        // the first byte of a load starts from a clean running state
        w_first       = (r_pos == 9'd0);
        w_code        = w_first ? 18'd0 : r_code;
        w_total       = w_first ? 10'd0 : r_total;
        w_failed      = w_first ? 1'b0 : r_failed;
        w_count_phase = (r_pos < 9'(jhd_pkg::NUM_LENGTHS));
        w_value_ok    = (r_pos < 9'(jhd_pkg::POS_END));
        w_li          = r_pos[3:0];

        w_sum   = 19'(w_code) + 19'(i_byte);
        w_lastc = w_sum - 19'd1;
        w_shift = {w_sum, 1'b0};
        w_tsum  = 11'(w_total) + 11'(i_byte);

        n_pos    = r_pos;
        n_code   = w_code;
        n_total  = w_total;
        n_failed = w_failed;

        if (w_count_phase) begin
            n_pos  = r_pos + 9'd1;
            n_code = (w_shift > 20'h20000) ? 18'h20000 : w_shift[17:0];
            n_total = (w_tsum > 11'd1023) ? 10'd1023 : w_tsum[9:0];
            if ((i_byte != 8'd0) && ((w_lastc > 19'h0FFFF) ||
                ((5'(w_li) + 5'd1) > 5'(jhd_pkg::MAX_CODE_LENGTH)))) begin
                n_failed = 1'b1;
            end
            if (n_total > 10'(jhd_pkg::MAX_SYMBOLS)) begin
                n_failed = 1'b1;
            end
        end else if (w_value_ok) begin
            n_pos = r_pos + 9'd1;
        end else begin
            n_failed = 1'b1;
        end

        w_ok = !n_failed && (n_pos >= 9'(jhd_pkg::NUM_LENGTHS)) &&
               (10'(n_pos - 9'(jhd_pkg::NUM_LENGTHS)) == n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_code     <= '0;
            r_total    <= '0;
            r_failed   <= 1'b0;
            r_ready    <= 1'b0;
            r_has_code <= '0;
        end else if (i_load) begin
            r_code   <= n_code;
            r_total  <= n_total;
            r_failed <= n_failed;
            if (w_count_phase) begin
                r_has_code[w_li] <= (i_byte != 8'd0);
            end
            if (i_last) begin
                r_pos   <= '0;
                r_ready <= w_ok;
            end else begin
                r_pos <= n_pos;
                if (w_first) begin
                    r_ready <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && w_count_phase) begin
            r_first_code[w_li]  <= w_code[15:0];
            r_last_code[w_li]   <= w_lastc[15:0];
            r_first_index[w_li] <= w_total[8:0];
        end
    end

    always_comb begin
        o_tbl.ready    = r_ready;
        o_tbl.has_code = r_has_code;
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            o_tbl.first_code[l]  = r_first_code[l];
            o_tbl.last_code[l]   = r_last_code[l];
            o_tbl.first_index[l] = r_first_index[l];
        end
    end

    assign o_res.valid = i_load && i_last;
    assign o_res.ok    = w_ok;

    assign o_wr.en   = i_load && !w_count_phase && w_value_ok;
    assign o_wr.addr = jhd_pkg::SYM_AW'(r_pos - 9'(jhd_pkg::NUM_LENGTHS));
    assign o_wr.data = i_byte;

endmodule

`default_nettype wire

// ===== rtl/core/jhd_code_match.sv =====
// compares the window against every code length and picks the shortest hit
// depends on jhd_pkg; gives status, length and symbol store address
`timescale 1ns / 1ps
`default_nettype none

module jhd_code_match (
    input  wire jhd_pkg::t_table  i_tbl,
    input  wire logic [15:0]      i_window,
    input  wire logic [4:0]       i_wbits,
    output jhd_pkg::t_match       o_res
);

    logic [4:0]  w_wb;
    logic [15:0] w_code [jhd_pkg::NUM_LENGTHS];
    logic [15:0] w_off  [jhd_pkg::NUM_LENGTHS];
    logic [jhd_pkg::SYM_AW-1:0] w_idx [jhd_pkg::NUM_LENGTHS];
    logic [jhd_pkg::NUM_LENGTHS-1:0] w_hit;
    logic [3:0]  w_sel;
    logic        w_found;
    logic [4:0]  w_len;

    always_comb begin
        w_wb = (i_wbits > 5'd16) ? 5'd16 : i_wbits;
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            w_code[l] = i_window >> (15 - l);
            w_off[l]  = w_code[l] - i_tbl.first_code[l];
            w_hit[l]  = i_tbl.ready && i_tbl.has_code[l] &&
                        (w_code[l] >= i_tbl.first_code[l]) &&
                        (w_code[l] <= i_tbl.last_code[l]);
            w_idx[l]  = jhd_pkg::SYM_AW'(i_tbl.first_index[l] + w_off[l][8:0]);
        end

        // shortest matching length wins
        w_sel   = '0;
        w_found = 1'b0;
        for (int l = jhd_pkg::NUM_LENGTHS - 1; l >= 0; l--) begin
            if (w_hit[l]) begin
                w_sel   = 4'(l);
                w_found = 1'b1;
            end
        end
        w_len = 5'(w_sel) + 5'd1;

        o_res.addr = w_idx[w_sel];
        o_res.len  = 5'd0;
        if (w_wb < 5'd8) begin
            o_res.status = jhd_pkg::ST_NO_DATA;
        end else if (w_found && (w_len <= w_wb)) begin
            o_res.status = jhd_pkg::ST_SYMBOL;
            o_res.len    = w_len;
        end else if (w_wb < 5'(jhd_pkg::MAX_CODE_LENGTH)) begin
            o_res.status = jhd_pkg::ST_NO_DATA;
        end else begin
            o_res.status = jhd_pkg::ST_BAD_CODE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_huffman_table_decoder_core.sv =====
// jpeg canonical huffman decoder: table load from dht bytes, symbol decode
// pipeline: an accepted item is registered in stage one, then in the output register, where the symbol store is read
// stage one takes a new item only once the one it holds has moved to the output register
// table bytes that are not last are taken every cycle while stage one is empty and give no result
// reset: synchronous active low; clears the pipeline, the load position and the table
// depends on jhd_pkg, jhd_table_builder, jhd_code_match, jhd_symbol_store
`timescale 1ns / 1ps
`default_nettype none

module jpeg_huffman_table_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // table_byte, bit_window, window_bits
    input  wire logic        i_s_axis_tlast,  // table_last
    input  wire logic        i_s_axis_tuser,  // mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // symbol, code_length
    output logic [2:0]       o_m_axis_tuser   // status
);

    jhd_pkg::t_table    w_tbl;
    jhd_pkg::t_load_res w_load;
    jhd_pkg::t_sym_wr   w_wr;
    jhd_pkg::t_match    w_match;

    logic        w_accept;
    logic        w_is_table;
    logic        w_s1_go;
    logic [7:0]  w_rd_data;

    logic                        r_s1_valid;
    jhd_pkg::t_status            r_s1_status;
    logic [4:0]                  r_s1_len;
    logic [jhd_pkg::SYM_AW-1:0]  r_s1_addr;
    logic                        r_out_valid;
    jhd_pkg::t_status            r_out_status;
    logic [4:0]                  r_out_len;

    assign o_s_axis_tready = !r_s1_valid;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_table = (i_s_axis_tuser == jhd_pkg::MODE_TABLE);
    assign w_s1_go    = r_s1_valid && (!r_out_valid || i_m_axis_tready);

    jhd_table_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && w_is_table),
        .i_byte  (i_s_axis_tdata[7:0]),
        .i_last  (i_s_axis_tlast),
        .o_tbl   (w_tbl),
        .o_res   (w_load),
        .o_wr    (w_wr)
    );

    jhd_code_match u_match (
        .i_tbl    (w_tbl),
        .i_window (i_s_axis_tdata[23:8]),
        .i_wbits  (i_s_axis_tdata[28:24]),
        .o_res    (w_match)
    );

    jhd_symbol_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_s1_go),
        .i_rd_addr (r_s1_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (!w_is_table || w_load.valid)) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_is_table) begin
                r_s1_status <= w_load.ok ? jhd_pkg::ST_TABLE_OK : jhd_pkg::ST_TABLE_BAD;
                r_s1_len    <= 5'd0;
                r_s1_addr   <= '0;
            end else begin
                r_s1_status <= w_match.status;
                r_s1_len    <= w_match.len;
                // only a hit gives a meaningful store address
                r_s1_addr   <= (w_match.status == jhd_pkg::ST_SYMBOL) ? w_match.addr : '0;
            end
        end
        if (w_s1_go) begin
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'd0, r_out_len,
                              (r_out_status == jhd_pkg::ST_SYMBOL) ? w_rd_data : 8'd0};

    // a decoded symbol always consumed at least one bit
    a_symbol_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == jhd_pkg::ST_SYMBOL)) |-> (r_out_len != 5'd0))
        else $error("symbol result with zero code length");

    // every other result carries no length
    a_other_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != jhd_pkg::ST_SYMBOL)) |-> (r_out_len == 5'd0))
        else $error("non-symbol result with nonzero code length");

    // a table byte that is not last gives no result
    a_silent_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_table && !i_s_axis_tlast) |=> !r_s1_valid)
        else $error("table byte produced a result");

    // a held result keeps the waiting item in place
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |=>
        (r_s1_valid && $stable(r_s1_status) && $stable(r_s1_addr)))
        else $error("waiting item lost under output stall");

endmodule

`default_nettype wire

// ===== tb/jpeg_huffman_table_decoder_checker.sv =====
// checker for the jpeg huffman table decoder: watches both stream channels,
// predicts every result from the accepted items and compares in order
// depends on jhd_pkg for the status codes and the decode mode
`timescale 1ns / 1ps

module jpeg_huffman_table_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,  // table_byte, bit_window, window_bits
    input  wire logic        i_s_tlast,  // table_last
    input  wire logic        i_s_tuser,  // mode
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,  // symbol, code_length
    input  wire logic [2:0]  i_m_tuser,  // status
    output int               o_fail_count,
    output int               o_results_due,
    output int               o_results_seen,
    output int               o_symbols_seen,
    output int               o_tables_seen
);

    typedef struct packed {
        jhd_pkg::t_status status;
        logic [7:0]       symbol;
        logic [4:0]       code_len;
    } t_huff_result;

    t_huff_result huff_results_due[$];

    // table as built from the count bytes
    logic [15:0] len_first_code  [jhd_pkg::NUM_LENGTHS];
    logic [15:0] len_last_code   [jhd_pkg::NUM_LENGTHS];
    logic        len_has_code    [jhd_pkg::NUM_LENGTHS];
    logic [8:0]  len_first_index [jhd_pkg::NUM_LENGTHS];
    logic [7:0]  sym_mem         [jhd_pkg::MAX_SYMBOLS];

    int unsigned load_pos;
    int unsigned code_acc;
    int unsigned total_acc;
    logic        load_bad;
    logic        tbl_ok;

    int fail_count   = 0;
    int results_seen = 0;
    int symbols_seen = 0;
    int tables_seen  = 0;

    function automatic void absorb_count(input int unsigned li, input int unsigned cnt);
        int unsigned last_code;
        len_first_code[li]  = code_acc[15:0];
        len_first_index[li] = total_acc[8:0];
        if (cnt == 0) begin
            len_has_code[li] = 1'b0;
        end else begin
            last_code = code_acc + cnt - 1;
            if (last_code > 32'hFFFF || li + 1 > jhd_pkg::MAX_CODE_LENGTH) begin
                load_bad = 1'b1;
            end
            len_has_code[li]  = 1'b1;
            len_last_code[li] = last_code[15:0];
        end
        total_acc = total_acc + cnt;
        if (total_acc > 1023) begin
            total_acc = 1023;
        end
        if (total_acc > jhd_pkg::MAX_SYMBOLS) begin
            load_bad = 1'b1;
        end
        code_acc = (code_acc + cnt) << 1;
        if (code_acc > 32'h20000) begin
            code_acc = 32'h20000;
        end
    endfunction

    // returns 1 when the byte closes a table and so gives a verdict
    function automatic bit absorb_table_byte(input logic [7:0] tbyte, input logic tlast,
                                             output t_huff_result verdict);
        bit ok;
        verdict = '0;
        if (load_pos == 0) begin
            code_acc  = 0;
            total_acc = 0;
            load_bad  = 1'b0;
            tbl_ok    = 1'b0;
        end
        if (load_pos < jhd_pkg::NUM_LENGTHS) begin
            absorb_count(load_pos, tbyte);
            load_pos++;
        end else if (load_pos - jhd_pkg::NUM_LENGTHS < jhd_pkg::MAX_SYMBOLS) begin
            sym_mem[(load_pos - jhd_pkg::NUM_LENGTHS) & 8'hFF] = tbyte;
            load_pos++;
        end else begin
            load_bad = 1'b1;
        end
        if (!tlast) begin
            return 1'b0;
        end
        ok = !load_bad && load_pos >= jhd_pkg::NUM_LENGTHS &&
             load_pos - jhd_pkg::NUM_LENGTHS == total_acc;
        tbl_ok   = ok;
        load_pos = 0;
        verdict.status = ok ? jhd_pkg::ST_TABLE_OK : jhd_pkg::ST_TABLE_BAD;
        return 1'b1;
    endfunction

    function automatic t_huff_result decode_window(input logic [15:0] win,
                                                   input logic [4:0] nb);
        t_huff_result res;
        int unsigned  nbits;
        int unsigned  code;
        int unsigned  idx;
        res = '0;
        res.status = jhd_pkg::ST_BAD_CODE;
        nbits = (nb > 16) ? 16 : nb;
        if (nbits < 8) begin
            res.status = jhd_pkg::ST_NO_DATA;
            return res;
        end
        for (int len = 1; len <= jhd_pkg::MAX_CODE_LENGTH; len++) begin
            if (len > nbits) begin
                res.status = jhd_pkg::ST_NO_DATA;
                return res;
            end
            code = 32'(win) >> (16 - len);
            if (tbl_ok && len_has_code[len-1] && code <= len_last_code[len-1] &&
                    code >= len_first_code[len-1]) begin
                idx = len_first_index[len-1] + code - len_first_code[len-1];
                res.status   = jhd_pkg::ST_SYMBOL;
                res.symbol   = sym_mem[idx & 8'hFF];
                res.code_len = 5'(len);
                return res;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_huff_result got;
        t_huff_result want;
        t_huff_result verdict;
        if (!i_rst_n) begin
            for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
                len_has_code[l] = 1'b0;
            end
            load_pos  = 0;
            code_acc  = 0;
            total_acc = 0;
            load_bad  = 1'b0;
            tbl_ok    = 1'b0;
            huff_results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status   = jhd_pkg::t_status'(i_m_tuser);
                got.symbol   = i_m_tdata[7:0];
                got.code_len = i_m_tdata[12:8];
                results_seen++;
                if (huff_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, got.status, got.symbol, got.code_len);
                end else begin
                    want = huff_results_due.pop_front();
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("symbol", want.symbol, got.symbol);
                    check_field("code length", 8'(want.code_len), 8'(got.code_len));
                    if (want.status == jhd_pkg::ST_SYMBOL) begin
                        symbols_seen++;
                    end
                    if (want.status == jhd_pkg::ST_TABLE_OK ||
                            want.status == jhd_pkg::ST_TABLE_BAD) begin
                        tables_seen++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == jhd_pkg::MODE_DECODE) begin
                    huff_results_due.push_back(decode_window(i_s_tdata[23:8],
                                                             i_s_tdata[28:24]));
                end else if (absorb_table_byte(i_s_tdata[7:0], i_s_tlast, verdict)) begin
                    huff_results_due.push_back(verdict);
                end
            end
        end
        o_results_due  <= huff_results_due.size();
        o_fail_count   <= fail_count;
        o_results_seen <= results_seen;
        o_symbols_seen <= symbols_seen;
        o_tables_seen  <= tables_seen;
    end

endmodule

// ===== tb/jpeg_huffman_table_decoder_core_test.sv =====
// top of the jpeg huffman table decoder test: clock, reset, table loads and
// decode items, receiver stalls; depends on jhd_pkg, the core and the checker
`timescale 1ns / 1ps

module jpeg_huffman_table_decoder_core_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 220;
    localparam int HOLD_CYCLES  = 300;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data  = '0;  // table_byte, bit_window, window_bits
    logic        s_last  = 1'b0;  // table_last
    logic        s_user  = 1'b0;  // mode
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;  // symbol, code_length
    logic [2:0]  m_user;  // status

    int fail_count;
    int results_due;
    int results_seen;
    int symbols_seen;
    int tables_seen;

    int items_sent  = 0;
    int cycle_count = 0;
    int hold_req    = 0;
    bit steady      = 1'b0;

    int         gen_cnt [jhd_pkg::NUM_LENGTHS];
    logic [7:0] table_q [$];

    jpeg_huffman_table_decoder_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    jpeg_huffman_table_decoder_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_valid),
        .i_s_tready     (s_ready),
        .i_s_tdata      (s_data),
        .i_s_tlast      (s_last),
        .i_s_tuser      (s_user),
        .i_m_tvalid     (m_valid),
        .i_m_tready     (m_ready),
        .i_m_tdata      (m_data),
        .i_m_tuser      (m_user),
        .o_fail_count   (fail_count),
        .o_results_due  (results_due),
        .o_results_seen (results_seen),
        .o_symbols_seen (symbols_seen),
        .o_tables_seen  (tables_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, a long hold-off on request, none while steady
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 15);
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] tbyte, input logic tlast,
                             input logic [15:0] win, input logic [4:0] wbits);
        while (!steady && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_last  <= tlast;
        s_data  <= {3'b000, wbits, win, tbyte};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_decode(input logic [15:0] win, input logic [4:0] wbits);
        send_item(jhd_pkg::MODE_DECODE, 8'($urandom), 1'($urandom), win, wbits);
    endtask

    // stop offering until every result is back, then let the table stage settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int table_total();
        int sum;
        sum = 0;
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            sum += gen_cnt[l];
        end
        return sum;
    endfunction

    function automatic void queue_table(input int n_values);
        table_q.delete();
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            table_q.push_back(8'(gen_cnt[l]));
        end
        repeat (n_values) table_q.push_back(8'($urandom));
    endfunction

    // counts that form a prefix-free code of up to n symbols
    function automatic void gen_kraft(input int n);
        int avail;
        int left;
        int lim;
        avail = 2;
        left  = n;
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            lim = (left < avail) ? left : avail;
            if (lim > 255) begin
                lim = 255;
            end
            if (l == jhd_pkg::NUM_LENGTHS - 1) begin
                gen_cnt[l] = lim;
            end else if ($urandom_range(2) == 0) begin
                gen_cnt[l] = 0;
            end else begin
                gen_cnt[l] = $urandom_range(lim);
            end
            left  -= gen_cnt[l];
            avail = (avail - gen_cnt[l]) * 2;
        end
    endfunction

    // window that starts with a valid code of the current counts
    function automatic logic [15:0] code_window();
        int lens [$];
        int first [jhd_pkg::NUM_LENGTHS];
        int code;
        int pick;
        int off;
        int shift;
        code = 0;
        for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
            first[l] = code;
            code = (code + gen_cnt[l]) << 1;
            if (gen_cnt[l] > 0) begin
                lens.push_back(l);
            end
        end
        if (lens.size() == 0) begin
            return 16'($urandom);
        end
        pick  = lens[$urandom_range(lens.size() - 1)];
        off   = $urandom_range(gen_cnt[pick] - 1);
        shift = 15 - pick;
        return 16'(((first[pick] + off) << shift) | ($urandom & ((1 << shift) - 1)));
    endfunction

    function automatic logic [4:0] pick_wbits();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 5'd16;
        end
        if (r < 80) begin
            return 5'($urandom_range(16, 8));
        end
        if (r < 90) begin
            return 5'($urandom_range(7));
        end
        return 5'($urandom_range(31, 17));
    endfunction

    // decodes slipped in between table bytes see the table cleared
    task automatic send_table(input int mid_pct);
        for (int i = 0; i < table_q.size(); i++) begin
            if (i > 0 && $urandom_range(99) < mid_pct) begin
                send_decode(16'($urandom), 5'd16);
            end
            send_item(jhd_pkg::MODE_TABLE, table_q[i], i == table_q.size() - 1,
                      16'($urandom), 5'($urandom));
        end
    endtask

    task automatic decode_burst(input int n);
        repeat (n) begin
            if ($urandom_range(9) < 7) begin
                send_decode(code_window(), pick_wbits());
            end else begin
                send_decode(16'($urandom), pick_wbits());
            end
        end
    endtask

    initial begin : stimulus
        int  rand_start;
        int  done;
        int  r;
        int  tot;
        bit  held;
        bit  drained;
        held    = 1'b0;
        drained = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no table yet
        send_decode(16'h0000, 5'd16);
        send_decode(16'hFFFF, 5'd0);
        send_decode(16'h1234, 5'd7);

        // typical dc-style table, decodes at the window extremes
        gen_cnt = '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
        queue_table(12);
        send_table(0);
        send_decode(16'h0000, 5'd16);
        send_decode(16'hFFFF, 5'd16);
        send_decode(16'hFFFF, 5'd8);
        send_decode(code_window(), 5'd31);
        send_decode(code_window(), 5'd17);
        send_decode(code_window(), 5'd8);
        decode_burst(6);

        // last flag while counts still arrive
        gen_kraft(8);
        queue_table(table_total());
        while (table_q.size() > 5) void'(table_q.pop_back());
        send_table(0);
        send_decode(code_window(), 5'd16);

        // empty table is accepted but matches nothing
        gen_cnt = '{default: 0};
        queue_table(0);
        send_table(0);
        send_decode(16'h0000, 5'd16);

        // value count too low, then too high
        gen_cnt = '{0, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        queue_table(2);
        send_table(0);
        queue_table(4);
        send_table(0);
        send_decode(code_window(), 5'd16);

        // counts add up past the symbol limit
        gen_cnt = '{default: 0};
        gen_cnt[8] = 255;
        gen_cnt[9] = 10;
        queue_table(1);
        send_table(0);

        // canonical code overflows sixteen bits
        gen_cnt = '{default: 0};
        gen_cnt[0]  = 2;
        gen_cnt[15] = 1;
        queue_table(3);
        send_table(0);

        // counts for every symbol but one value byte more than the store holds
        gen_cnt = '{default: 0};
        gen_cnt[7] = 255;
        gen_cnt[8] = 1;
        queue_table(257);
        send_table(3);
        send_decode(16'h0000, 5'd16);
        wait_drained();

        rand_start = items_sent;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (!held && done > 40) begin
                hold_req <= hold_req + 1;
                held = 1'b1;
            end
            if (!drained && done > 100) begin
                wait_drained();
                drained = 1'b1;
            end
            steady <= (done >= 130 && done < 190);

            r = $urandom_range(99);
            if (r < 60) begin
                gen_kraft(($urandom_range(24) == 0) ? $urandom_range(256, 100)
                                                    : $urandom_range(24, 1));
                queue_table(table_total());
                send_table(5);
            end else if (r < 70) begin
                gen_kraft($urandom_range(24, 1));
                tot = table_total();
                queue_table(($urandom_range(1) == 0 && tot > 0) ? tot - 1 : tot + 1);
                send_table(5);
            end else if (r < 75) begin
                gen_kraft($urandom_range(24, 1));
                queue_table(table_total());
                while (table_q.size() > $urandom_range(15, 1)) void'(table_q.pop_back());
                send_table(0);
            end else if (r < 85) begin
                for (int l = 0; l < jhd_pkg::NUM_LENGTHS; l++) begin
                    gen_cnt[l] = ($urandom_range(9) == 0) ? $urandom_range(255)
                                                          : $urandom_range(3);
                end
                tot = table_total();
                queue_table((tot <= 40) ? tot : $urandom_range(20));
                send_table(0);
            end
            decode_burst($urandom_range(25, 5));
            done = items_sent - rand_start;
        end
        steady <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        $display("run covered %0d input items and %0d results, %0d table verdicts, %0d symbols",
                 items_sent, results_seen, tables_seen, symbols_seen);
        $display("tables of every rejection kind, windows of 0 to 31 valid bits, stalls both sides");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
